### rtl/core/rpn_pkg.sv
// Shared constants, codes and types of the RPN stack calculator.
package rpn_pkg;

   // Stack geometry.
   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

   // Value and arithmetic unit widths.
   localparam int VALUE_W    = 32;
   localparam int WIDE_W     = 48;
   localparam int MUL_STEPS  = 32;
   localparam int DIV_STEPS  = 48;
   localparam int STEP_W     = $clog2(DIV_STEPS + 1);

   // Token codes on the request channel.
   typedef enum logic [3:0] {
      CMD_PUSH    = 4'd0,
      CMD_ADD     = 4'd1,
      CMD_SUB     = 4'd2,
      CMD_MUL     = 4'd3,
      CMD_DIV     = 4'd4,
      CMD_MOD     = 4'd5,
      CMD_PEEK    = 4'd6,
      CMD_POP     = 4'd7,
      CMD_CLEAR   = 4'd8,
      CMD_SWAP    = 4'd9,
      CMD_NOP     = 4'd10,
      CMD_UNKNOWN = 4'd11
   } cmd_type;

   // Status codes on the response channel.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ZERO_DIV  = 3'd1,
      ST_NEG_MOD   = 3'd2,
      ST_UNKNOWN   = 3'd3,
      ST_UNDERFLOW = 3'd4,
      ST_OVERFLOW  = 3'd5
   } status_type;

   // Operations of the shared arithmetic unit.
   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV,
      ALU_MOD
   } alu_op_type;

   // Start request into the arithmetic unit.
   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   // Completion from the arithmetic unit.
   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] value;
   } alu_rsp_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WAIT_B,
      S_POP_A,
      S_WAIT_A,
      S_EXEC,
      S_ALU,
      S_READ,
      S_SWAP_1,
      S_SWAP_2,
      S_SWAP_3,
      S_FINISH
   } fsm_state_type;

endpackage

### rtl/core/rpn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/rpn_alu.sv
// Shared iterative arithmetic unit: saturating add and subtract, shift-add
// multiply and restoring divide for Q16.16 values and integer modulo.
module rpn_alu import rpn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  alu_req_type        alu_req,
   input  logic [VALUE_W-1:0] oper_a,
   input  logic [VALUE_W-1:0] oper_b,
   output alu_rsp_type        alu_rsp
);

   // Absolute value of a two's complement word, as an unsigned word.
   function automatic logic [VALUE_W-1:0] magnitude(input logic [VALUE_W-1:0] x);
      return x[VALUE_W-1] ? (VALUE_W'(0) - x) : x;
   endfunction

   // Apply the sign to a wide magnitude and clamp to the Q16.16 range.
   function automatic logic [VALUE_W-1:0] saturate(input logic [WIDE_W-1:0] mag,
                                                   input logic neg);
      logic [VALUE_W-1:0] r;
      if (neg) begin
         if (mag > {{(WIDE_W-VALUE_W){1'b0}}, 1'b1, {(VALUE_W-1){1'b0}}}) begin
            r = {1'b1, {(VALUE_W-1){1'b0}}};
         end else begin
            r = VALUE_W'(0) - mag[VALUE_W-1:0];
         end
      end else begin
         if (mag > {{(WIDE_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}}) begin
            r = {1'b0, {(VALUE_W-1){1'b1}}};
         end else begin
            r = mag[VALUE_W-1:0];
         end
      end
      return r;
   endfunction

   logic                busy_ff, busy_in;
   logic                fin_ff, fin_in;
   alu_op_type          op_ff, op_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                neg_ff, neg_in;
   logic [VALUE_W:0]    hi_ff, hi_in;
   logic [WIDE_W-1:0]   lo_ff, lo_in;
   logic [VALUE_W-1:0]  y_ff, y_in;

   logic [VALUE_W:0]    mul_sum;
   logic [VALUE_W:0]    div_shift;
   logic [VALUE_W+1:0]  div_diff;
   logic [VALUE_W-1:0]  mag_a;
   logic [VALUE_W-1:0]  mag_b;

   assign mag_a = magnitude(oper_a);
   assign mag_b = magnitude(oper_b);

   // One step of each iterative operation: an add for multiply, a trial
   // subtract for divide.
   assign mul_sum   = {1'b0, hi_ff[VALUE_W-1:0]} + {1'b0, (lo_ff[0] ? y_ff : '0)};
   assign div_shift = {hi_ff[VALUE_W-1:0], lo_ff[WIDE_W-1]};
   assign div_diff  = {1'b0, div_shift} - {2'b00, y_ff};

   // Operand load and iteration control.
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      op_in   = op_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      y_in    = y_ff;
      if (alu_req.start) begin
         op_in = alu_req.op;
         case (alu_req.op)
            ALU_ADD: begin
               hi_in  = {oper_a[VALUE_W-1], oper_a} + {oper_b[VALUE_W-1], oper_b};
               fin_in = 1'b1;
            end
            ALU_SUB: begin
               hi_in  = {oper_a[VALUE_W-1], oper_a} - {oper_b[VALUE_W-1], oper_b};
               fin_in = 1'b1;
            end
            ALU_MUL: begin
               hi_in   = '0;
               lo_in   = {{(WIDE_W-VALUE_W){1'b0}}, mag_b};
               y_in    = mag_a;
               neg_in  = oper_a[VALUE_W-1] ^ oper_b[VALUE_W-1];
               step_in = STEP_W'(MUL_STEPS);
               busy_in = 1'b1;
            end
            ALU_DIV: begin
               hi_in   = '0;
               lo_in   = {mag_a, {(WIDE_W-VALUE_W){1'b0}}};
               y_in    = mag_b;
               neg_in  = oper_a[VALUE_W-1] ^ oper_b[VALUE_W-1];
               step_in = STEP_W'(DIV_STEPS);
               busy_in = 1'b1;
            end
            default: begin
               // Modulo works on the integer parts of two non-negative values.
               hi_in   = '0;
               lo_in   = {{(WIDE_W-15){1'b0}}, oper_a[30:16]};
               y_in    = {{(VALUE_W-15){1'b0}}, oper_b[30:16]};
               neg_in  = 1'b0;
               step_in = STEP_W'(DIV_STEPS);
               busy_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         if (op_ff == ALU_MUL) begin
            hi_in = {1'b0, mul_sum[VALUE_W:1]};
            lo_in = {{(WIDE_W-VALUE_W){1'b0}}, mul_sum[0], lo_ff[VALUE_W-1:1]};
         end else if (!div_diff[VALUE_W+1]) begin
            hi_in = div_diff[VALUE_W:0];
            lo_in = {lo_ff[WIDE_W-2:0], 1'b1};
         end else begin
            hi_in = div_shift;
            lo_in = {lo_ff[WIDE_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      y_ff    <= y_in;
   end

   // Final scaling and saturation of the finished operation.
   always_comb begin
      alu_rsp.done = fin_ff;
      case (op_ff)
         ALU_ADD, ALU_SUB: begin
            if (hi_ff[VALUE_W] != hi_ff[VALUE_W-1]) begin
               alu_rsp.value = hi_ff[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                              : {1'b0, {(VALUE_W-1){1'b1}}};
            end else begin
               alu_rsp.value = hi_ff[VALUE_W-1:0];
            end
         end
         ALU_MUL: alu_rsp.value = saturate({hi_ff[VALUE_W-1:0], lo_ff[VALUE_W-1:16]}, neg_ff);
         ALU_DIV: alu_rsp.value = saturate(lo_ff, neg_ff);
         default: alu_rsp.value = {1'b0, hi_ff[14:0], 16'h0000};
      endcase
   end

endmodule

### rtl/core/rpn_stack_calculator.sv
// Reverse Polish stack calculator on signed Q16.16 values.
//
// Usage: a request transaction carries one token (req_type and
// req_number_value) on a valid/stall channel; every token gives exactly one
// response transaction with rsp_status, rsp_result_value and
// rsp_result_valid. Tokens are handled one at a time: req_stall is low only
// while the sequencer is idle. Push, clear, no-op and unknown tokens go from
// decode straight to the finishing state; peek and pop add a stack read;
// swap reads the two top entries and writes them back crossed; arithmetic
// pops its operands and runs the shared arithmetic unit, which retires one
// multiplier bit or one quotient bit per cycle (32 and 48 steps). Zero
// divisor and negative modulo errors skip the unit. Stack memory reads go
// through the registered read port.
// The next request is taken the cycle after the response is registered.
// Reset empties the stack (the count goes to zero, memory contents are left
// as they are) and drops any pending response. When the receiver stalls,
// the response is held in the output register; the next token can still be
// accepted and run, then waits in the finishing state, and no new request
// is taken until that response leaves.
module rpn_stack_calculator import rpn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_type,
   input  logic [VALUE_W-1:0] req_number_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [VALUE_W-1:0] rsp_result_value,
   output logic               rsp_result_valid
);

   fsm_state_type       state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   cmd_type             kind_ff, kind_in;
   logic [VALUE_W-1:0]  num_ff, num_in;
   logic [VALUE_W-1:0]  a_ff, a_in;
   logic [VALUE_W-1:0]  b_ff, b_in;
   status_type          status_ff, status_in;
   logic                under_ff, under_in;
   logic [VALUE_W-1:0]  res_ff, res_in;
   logic                rvalid_ff, rvalid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_rvalid_ff, rsp_rvalid_in;

   logic [COUNT_W-1:0]  count_m1;
   logic [COUNT_W-1:0]  count_m2;
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [VALUE_W-1:0]  ram_wdata;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [VALUE_W-1:0]  ram_rdata;
   alu_req_type         alu_req;
   alu_rsp_type         alu_rsp;
   alu_op_type          alu_op;

   assign count_m1 = count_ff - COUNT_W'(1);
   assign count_m2 = count_ff - COUNT_W'(2);

   // Stack storage.
   rpn_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Shared arithmetic unit.
   rpn_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .oper_a  (a_ff),
      .oper_b  (b_ff),
      .alu_rsp (alu_rsp)
   );

   // Map the token to the arithmetic operation.
   always_comb begin
      case (kind_ff)
         CMD_ADD: alu_op = ALU_ADD;
         CMD_SUB: alu_op = ALU_SUB;
         CMD_MUL: alu_op = ALU_MUL;
         CMD_DIV: alu_op = ALU_DIV;
         default: alu_op = ALU_MOD;
      endcase
   end

   // Sequencer: next state, stack access and response loading.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      kind_in       = kind_ff;
      num_in        = num_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      status_in     = status_ff;
      under_in      = under_ff;
      res_in        = res_ff;
      rvalid_in     = rvalid_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      ram_we        = 1'b0;
      ram_waddr     = count_ff[ADDR_W-1:0];
      ram_wdata     = num_ff;
      ram_raddr     = count_m1[ADDR_W-1:0];
      alu_req.start = 1'b0;
      alu_req.op    = alu_op;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = cmd_type'(req_type);
               num_in    = req_number_value;
               status_in = ST_OK;
               under_in  = 1'b0;
               res_in    = '0;
               rvalid_in = 1'b0;
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_FINISH;
            case (kind_ff)
               CMD_PUSH: begin
                  if (count_ff >= COUNT_W'(STACK_DEPTH)) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     ram_we   = 1'b1;
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
               CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
                  // Pop the right operand; an empty stack yields zero.
                  if (count_ff == '0) begin
                     b_in     = '0;
                     under_in = 1'b1;
                     if (kind_ff == CMD_DIV) begin
                        status_in = ST_ZERO_DIV;
                     end else begin
                        state_in = S_POP_A;
                     end
                  end else begin
                     count_in = count_m1;
                     state_in = S_WAIT_B;
                  end
               end
               CMD_PEEK: begin
                  rvalid_in = 1'b1;
                  if (count_ff == '0) begin
                     under_in = 1'b1;
                  end else begin
                     state_in = S_READ;
                  end
               end
               CMD_POP: begin
                  rvalid_in = 1'b1;
                  if (count_ff == '0) begin
                     under_in = 1'b1;
                  end else begin
                     count_in = count_m1;
                     state_in = S_READ;
                  end
               end
               CMD_CLEAR: begin
                  count_in = '0;
               end
               CMD_SWAP: begin
                  if (count_ff < COUNT_W'(2)) begin
                     under_in = 1'b1;
                  end else begin
                     state_in = S_SWAP_1;
                  end
               end
               CMD_NOP: begin
                  state_in = S_FINISH;
               end
               default: begin
                  status_in = ST_UNKNOWN;
               end
            endcase
         end

         S_WAIT_B: begin
            b_in = ram_rdata;
            if (kind_ff == CMD_DIV && ram_rdata == '0) begin
               status_in = ST_ZERO_DIV;
               state_in  = S_FINISH;
            end else begin
               state_in = S_POP_A;
            end
         end

         S_POP_A: begin
            // Pop the left operand; an empty stack yields zero.
            if (count_ff == '0) begin
               a_in     = '0;
               under_in = 1'b1;
               state_in = S_EXEC;
            end else begin
               count_in = count_m1;
               state_in = S_WAIT_A;
            end
         end

         S_WAIT_A: begin
            a_in     = ram_rdata;
            state_in = S_EXEC;
         end

         S_EXEC: begin
            if (kind_ff == CMD_MOD && (a_ff[VALUE_W-1] || b_ff[VALUE_W-1])) begin
               status_in = ST_NEG_MOD;
               state_in  = S_FINISH;
            end else if (kind_ff == CMD_MOD && b_ff[30:16] == '0) begin
               status_in = ST_ZERO_DIV;
               state_in  = S_FINISH;
            end else begin
               alu_req.start = 1'b1;
               state_in      = S_ALU;
            end
         end

         S_ALU: begin
            // The operand pops left the stack below its depth, so the result always has room.
            if (alu_rsp.done) begin
               ram_we    = 1'b1;
               ram_wdata = alu_rsp.value;
               count_in  = count_ff + COUNT_W'(1);
               state_in  = S_FINISH;
            end
         end

         S_READ: begin
            res_in   = ram_rdata;
            state_in = S_FINISH;
         end

         S_SWAP_1: begin
            b_in      = ram_rdata;
            ram_raddr = count_m2[ADDR_W-1:0];
            state_in  = S_SWAP_2;
         end

         S_SWAP_2: begin
            ram_we    = 1'b1;
            ram_waddr = count_m1[ADDR_W-1:0];
            ram_wdata = ram_rdata;
            state_in  = S_SWAP_3;
         end

         S_SWAP_3: begin
            ram_we    = 1'b1;
            ram_waddr = count_m2[ADDR_W-1:0];
            ram_wdata = b_ff;
            state_in  = S_FINISH;
         end

         S_FINISH: begin
            // Load the response register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = under_ff ? ST_UNDERFLOW : status_ff;
               rsp_value_in  = res_ff;
               rsp_rvalid_in = rvalid_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Token and response payload registers.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      num_ff        <= num_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      status_ff     <= status_in;
      under_ff      <= under_in;
      res_ff        <= res_in;
      rvalid_ff     <= rvalid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_valid = rsp_rvalid_ff;

   // The stack count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(STACK_DEPTH))
      else $error("stack count exceeds depth");

   // The arithmetic unit only completes while the sequencer waits for it.
   a_alu_done_in_alu: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> state_ff == S_ALU)
      else $error("arithmetic unit completed outside its state");

   // An accepted transaction closes the request channel on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a token is in progress");

   // A new response only comes out of the finishing state.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_FINISH)
      else $error("response raised outside the finishing state");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the RPN stack calculator: directed, stack-fill and random tokens.
module tb_top import rpn_pkg::*; ();

   // Q16.16 word as carried on the ports.
   typedef logic signed [VALUE_W-1:0] q16_type;

   // One expected response transaction.
   typedef struct {
      logic [3:0] code;
      status_type status;
      q16_type    value;
      logic       has_value;
   } rsp_expect_type;

   localparam int      HALF_PERIOD  = 5;
   localparam int      RESET_CYCLES = 6;
   localparam int      CYCLE_LIMIT  = 1_000_000;
   localparam int      DRAIN_CYCLES = 80;
   localparam int      MAX_GAP      = 40;
   localparam int      LONG_HOLD    = 400;
   localparam int      PHASE_TOKENS = 190;
   localparam longint  SAT_HIGH     = 64'sd2147483647;
   localparam longint  SAT_LOW      = -64'sd2147483648;
   localparam q16_type Q16_MAX_WORD = 32'sh7FFF_FFFF;
   localparam q16_type Q16_MIN_WORD = 32'sh8000_0000;
   localparam q16_type Q16_ONE      = 32'sh0001_0000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [3:0] req_type = CMD_NOP;
   q16_type    req_number_value = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   q16_type    rsp_result_value;
   logic       rsp_result_valid;

   // Predicted stack contents.
   q16_type calc_stack [STACK_DEPTH];
   int      calc_count = 0;
   logic    calc_under;

   rsp_expect_type expected_results [$];

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  offering = 1'b0;
   int  hold_len = 0;
   int  hold_seq = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  cycle_count = 0;
   int  fail_count = 0;
   int  tokens_sent = 0;
   int  results_checked = 0;
   int  status_seen [8];

   rpn_stack_calculator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_number_value (req_number_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_result_valid (rsp_result_valid)
   );

   // Free-running clock.
   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Run limit in case the block stops answering.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver back-pressure: long holds on request, random stalls otherwise.
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Compare every accepted response transaction with the oldest prediction.
   always @(posedge clock) begin : check_responses
      rsp_expect_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("response transaction arrived with nothing pending");
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, actual %0d (token %0d)",
                      want.status, rsp_status, want.code);
               fail_count++;
            end
            if (rsp_result_value !== want.value) begin
               $error("rsp_result_value: expected %h, actual %h (token %0d)",
                      want.value, rsp_result_value, want.code);
               fail_count++;
            end
            if (rsp_result_valid !== want.has_value) begin
               $error("rsp_result_valid: expected %0d, actual %0d (token %0d)",
                      want.has_value, rsp_result_valid, want.code);
               fail_count++;
            end
            results_checked++;
            status_seen[int'(want.status)]++;
         end
      end
   end

   // Clamp a wide arithmetic result into the Q16.16 range.
   function automatic q16_type saturate(longint v);
      if (v > SAT_HIGH) return Q16_MAX_WORD;
      if (v < SAT_LOW) return Q16_MIN_WORD;
      return q16_type'(v);
   endfunction

   // Pop one operand; an empty stack yields zero and marks underflow.
   function automatic q16_type calc_pop();
      if (calc_count == 0) begin
         calc_under = 1'b1;
         return '0;
      end
      calc_count--;
      return calc_stack[calc_count];
   endfunction

   // Push one value; the caller decides what a full stack means.
   function automatic void calc_push(q16_type v);
      if (calc_count < STACK_DEPTH) begin
         calc_stack[calc_count] = v;
         calc_count++;
      end
   endfunction

   // Apply one token to the predicted stack and return the expected response.
   function automatic rsp_expect_type calculate_token(logic [3:0] code, q16_type num);
      rsp_expect_type r;
      q16_type        a;
      q16_type        b;
      q16_type        t;
      longint         wide;
      int             ia;
      int             ib;
      r.code      = code;
      r.status    = ST_OK;
      r.value     = '0;
      r.has_value = 1'b0;
      calc_under  = 1'b0;
      case (code)
         CMD_PUSH: begin
            if (calc_count >= STACK_DEPTH) r.status = ST_OVERFLOW;
            else calc_push(num);
         end
         CMD_ADD: begin
            b = calc_pop();
            a = calc_pop();
            calc_push(saturate(longint'(a) + longint'(b)));
         end
         CMD_SUB: begin
            b = calc_pop();
            a = calc_pop();
            calc_push(saturate(longint'(a) - longint'(b)));
         end
         CMD_MUL: begin
            b = calc_pop();
            a = calc_pop();
            wide = longint'(a) * longint'(b);
            calc_push(saturate(wide / 64'sd65536));
         end
         CMD_DIV: begin
            // A zero divisor leaves the dividend on the stack.
            b = calc_pop();
            if (b == 0) begin
               r.status = ST_ZERO_DIV;
            end else begin
               a = calc_pop();
               wide = longint'(a) * 64'sd65536;
               calc_push(saturate(wide / longint'(b)));
            end
         end
         CMD_MOD: begin
            // Both operands are consumed; only integer parts take part.
            b = calc_pop();
            a = calc_pop();
            if (a < 0 || b < 0) begin
               r.status = ST_NEG_MOD;
            end else begin
               ia = int'(a) / 65536;
               ib = int'(b) / 65536;
               if (ib == 0) r.status = ST_ZERO_DIV;
               else calc_push(q16_type'((ia % ib) * 65536));
            end
         end
         CMD_PEEK: begin
            r.has_value = 1'b1;
            if (calc_count == 0) calc_under = 1'b1;
            else r.value = calc_stack[calc_count - 1];
         end
         CMD_POP: begin
            r.has_value = 1'b1;
            r.value = calc_pop();
         end
         CMD_CLEAR: begin
            calc_count = 0;
         end
         CMD_SWAP: begin
            if (calc_count < 2) begin
               calc_under = 1'b1;
            end else begin
               t = calc_stack[calc_count - 1];
               calc_stack[calc_count - 1] = calc_stack[calc_count - 2];
               calc_stack[calc_count - 2] = t;
            end
         end
         CMD_NOP: begin
         end
         default: begin
            r.status = ST_UNKNOWN;
         end
      endcase
      // Underflow wins over any other error of the same token.
      if (calc_under) r.status = ST_UNDERFLOW;
      return r;
   endfunction

   // Operand mix: small integers, mixed fractions, raw words and range corners.
   function automatic q16_type random_q16();
      q16_type v;
      int      sel;
      sel = $urandom_range(0, 7);
      case (sel)
         0: v = {16'($urandom_range(0, 20)), 16'h0000};
         1: v = {16'($urandom_range(0, 300)), 16'($urandom)};
         2: v = {16'h0000, 16'($urandom)};
         3: begin
            case ($urandom_range(0, 4))
               0: v = Q16_MAX_WORD;
               1: v = Q16_MIN_WORD;
               2: v = '0;
               3: v = Q16_ONE;
               default: v = '1;
            endcase
         end
         default: v = $urandom;
      endcase
      if (sel <= 2 && $urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   // Offer one request transaction, wait for its handshake, record the prediction.
   task automatic send_token(logic [3:0] code, q16_type num);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         if (offering) req_valid <= 1'b0;
         offering = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= code;
      req_number_value <= num;
      offering = 1'b1;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(calculate_token(code, num));
      tokens_sent++;
   endtask

   // Stop offering and wait until every predicted response has been taken.
   task automatic wait_for_drain();
      if (offering) req_valid <= 1'b0;
      offering = 1'b0;
      while (expected_results.size() > 0) @(posedge clock);
   endtask

   // Ask the receiver process for a long stall of the given length.
   task automatic hold_output(int cycles);
      hold_len = cycles;
      hold_seq++;
   endtask

   // Corner values, every command and the error cases in a short fixed sequence.
   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct     = 0;
      // Empty stack: pop, peek, swap, divide and add all underflow.
      send_token(CMD_POP, '0);
      send_token(CMD_PEEK, '0);
      send_token(CMD_SWAP, '0);
      send_token(CMD_DIV, '0);
      send_token(CMD_ADD, '0);
      // Saturation of add, multiply and divide, with a zero divisor before the divide.
      send_token(CMD_PUSH, Q16_MAX_WORD);
      send_token(CMD_PUSH, Q16_MAX_WORD);
      send_token(CMD_ADD, '0);
      send_token(CMD_PUSH, -32'sh0001_8000);
      send_token(CMD_MUL, '0);
      send_token(CMD_PUSH, '0);
      send_token(CMD_DIV, '0);
      send_token(CMD_PUSH, '1);
      send_token(CMD_DIV, '0);
      // Modulo with a negative operand, then a regular modulo.
      send_token(CMD_PUSH, -32'sh0003_0000);
      send_token(CMD_PUSH, 32'sh0002_0000);
      send_token(CMD_MOD, '0);
      send_token(CMD_PUSH, 32'sh0009_4000);
      send_token(CMD_PUSH, 32'sh0004_0000);
      send_token(CMD_MOD, '0);
      send_token(CMD_SWAP, '0);
      send_token(CMD_PEEK, '0);
      send_token(CMD_POP, '0);
      send_token(CMD_NOP, Q16_MIN_WORD);
      send_token(CMD_UNKNOWN, '0);
      send_token(4'(CMD_UNKNOWN + 2), '1);
      send_token(CMD_CLEAR, '0);
      wait_for_drain();
   endtask

   // Fill the stack past its depth while the output is held off for a long time.
   task automatic test_stack_fill();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_output(LONG_HOLD);
      repeat (STACK_DEPTH + 2) send_token(CMD_PUSH, random_q16());
      send_token(CMD_MUL, '0);
      send_token(CMD_PUSH, random_q16());
      send_token(CMD_PUSH, random_q16());
      send_token(CMD_SWAP, '0);
      send_token(CMD_PEEK, '0);
      send_token(CMD_POP, '0);
      send_token(CMD_CLEAR, '0);
      wait_for_drain();
   endtask

   // One random token, biased toward commands that find their operands.
   task automatic send_random_token();
      logic [3:0] code;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 42) code = CMD_PUSH;
      else if (pick < 72) code = 4'(CMD_ADD + $urandom_range(0, 4));
      else if (pick < 80) code = ($urandom_range(0, 1) == 1) ? CMD_PEEK : CMD_POP;
      else if (pick < 85) code = CMD_SWAP;
      else if (pick < 88) code = CMD_CLEAR;
      else if (pick < 92) code = CMD_NOP;
      else if (pick < 95) code = 4'(CMD_UNKNOWN + $urandom_range(0, 4));
      else code = CMD_PUSH;
      // Most arithmetic gets two operands; a few run short on purpose.
      if (code >= CMD_ADD && code <= CMD_MOD && calc_count < 2 &&
          $urandom_range(0, 9) < 8) code = CMD_PUSH;
      // Near the top, pushes mostly turn into reductions.
      if (code == CMD_PUSH && calc_count > STACK_DEPTH - 8 &&
          $urandom_range(0, 3) != 0) code = CMD_ADD;
      send_token(code, random_q16());
   endtask

   // A random phase under the given idling, then a pause until it drains.
   task automatic test_random_phase(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
      repeat (PHASE_TOKENS) send_random_token();
      wait_for_drain();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_stack_fill();
      test_random_phase(0, 0);
      test_random_phase(78, 0);
      test_random_phase(0, 78);
      test_random_phase(11, 11);
      stall_pct = 0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d tokens: directed corners, a stack filled past its depth",
               tokens_sent);
      $display("under a long hold, and four random idling phases; %0d responses seen",
               results_checked);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/rpn_pkg.sv
rtl/core/rpn_ram.sv
rtl/core/rpn_alu.sv
rtl/core/rpn_stack_calculator.sv
dv/tb_top.sv
